// ===== rtl/tbcwd_pkg.sv =====
package tbcwd_pkg;

  localparam int unsigned CODE_W    = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WIN_DEPTH = 256;
  localparam int unsigned WIN_AW    = 8;
  localparam int unsigned RUN_W     = 4;
  localparam int unsigned CNT_W     = 4;

  localparam logic [1:0] SEL_LIT   = 2'b00;
  localparam logic [1:0] SEL_RUN4  = 2'b01;
  localparam logic [1:0] SEL_RUN8  = 2'b10;
  localparam logic [1:0] SEL_RUN16 = 2'b11;

  localparam logic [RUN_W-1:0] RUN4_END  = 4'd3;
  localparam logic [RUN_W-1:0] RUN8_END  = 4'd7;
  localparam logic [RUN_W-1:0] RUN16_END = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic lit_wr;
    logic copy_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic code_done;
    logic is_lit;
    logic run_end;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== rtl/tbcwd_in_if.sv =====
interface tbcwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

// ===== rtl/tbcwd_out_if.sv =====
interface tbcwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       last_of_run;

  modport source (output valid, output plain_byte, output last_of_run, input ready);
  modport sink (input valid, input plain_byte, input last_of_run, output ready);
endinterface

// ===== rtl/tbcwd_ctrl.sv =====
module tbcwd_ctrl
  import tbcwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.code_done) begin
          state_d = sts_i.is_lit ? ST_LIT : ST_COPY;
        end
      end
      ST_LIT: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (sts_i.slot_free && sts_i.run_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_LIT: begin
        cmd_o.lit_wr = sts_i.slot_free;
      end
      ST_COPY: begin
        cmd_o.copy_rd = sts_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/tbcwd_dp.sv =====
module tbcwd_dp
  import tbcwd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] code_byte_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] plain_byte_o,
  output logic              last_of_run_o
);

  logic [CODE_W-1:0]    accum_q, accum_d;
  logic [CNT_W-1:0]     bits_q, bits_d;
  logic [WIN_AW-1:0]    wp_q;
  logic [WIN_DEPTH-1:0] vld_q;
  logic                 out_valid_q;
  logic                 out_last_q;
  logic                 src_mem_q;
  logic                 rd_vld_q;

  logic [BYTE_W-1:0]    win_mem [WIN_DEPTH];
  logic [BYTE_W-1:0]    rd_data_q;
  logic [BYTE_W-1:0]    lit_q;
  logic [WIN_AW-1:0]    addr_q;
  logic [RUN_W-1:0]     run_q;

  logic [CODE_W+BYTE_W-1:0] stream;
  logic [2:0]               sh;
  logic [CODE_W-1:0]        code;
  logic [BYTE_W-1:0]        rem_mask;
  logic                     done;
  logic [RUN_W-1:0]         run_end_idx;

  // The accumulator holds only as many low bits as the bit count says, so the
  // bit stream so far is the accumulator followed by the new byte.
  assign stream   = {accum_q, code_byte_i};
  assign done     = (bits_q >= 4'd2);
  assign sh       = 3'(bits_q - 4'd2);
  assign code     = CODE_W'(stream >> sh);
  assign rem_mask = ~(8'hFF << sh);

  always_comb begin
    if (done) begin
      accum_d = CODE_W'(code_byte_i & rem_mask);
      bits_d  = CNT_W'(sh);
    end else begin
      accum_d = stream[CODE_W-1:0];
      bits_d  = bits_q + 4'd8;
    end
  end

  always_comb begin
    case (code[CODE_W-1:CODE_W-2])
      SEL_RUN4:  run_end_idx = RUN4_END;
      SEL_RUN8:  run_end_idx = RUN8_END;
      SEL_RUN16: run_end_idx = RUN16_END;
      default:   run_end_idx = '0;
    endcase
  end

  assign sts_o.code_done = done;
  assign sts_o.is_lit    = (code[CODE_W-1:CODE_W-2] == SEL_LIT);
  assign sts_o.run_end   = (run_q == '0);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      bits_q      <= '0;
      wp_q        <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      src_mem_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        accum_q <= accum_d;
        bits_q  <= bits_d;
      end
      if (cmd_i.lit_wr) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= wp_q + 8'd1;
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        src_mem_q   <= 1'b0;
      end else if (cmd_i.copy_rd) begin
        rd_vld_q    <= vld_q[addr_q];
        out_valid_q <= 1'b1;
        out_last_q  <= (run_q == '0);
        src_mem_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && done) begin
      addr_q <= code[BYTE_W-1:0];
      run_q  <= run_end_idx;
    end else if (cmd_i.copy_rd) begin
      addr_q <= addr_q + 8'd1;
      run_q  <= run_q - 4'd1;
    end
    if (cmd_i.lit_wr) begin
      lit_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lit_wr) begin
      win_mem[wp_q] <= addr_q;
    end
    if (cmd_i.copy_rd) begin
      rd_data_q <= win_mem[addr_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign last_of_run_o = out_last_q;
  assign plain_byte_o  = src_mem_q ? (rd_vld_q ? rd_data_q : '0) : lit_q;

`ifndef ASSERT_OFF
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q < 4'(CODE_W))
    else $error("bit count out of range");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.lit_wr && cmd_i.copy_rd) && !(cmd_i.take && (cmd_i.lit_wr || cmd_i.copy_rd)))
    else $error("conflicting datapath commands");

  a_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy_rd && (run_q == '0) |=> out_valid_q && out_last_q)
    else $error("final copy byte not marked last");

  a_lit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lit_wr |=> vld_q[$past(wp_q)] && out_last_q && !src_mem_q)
    else $error("literal write not recorded");
`endif

endmodule

// ===== rtl/ten_bit_code_window_decompressor.sv =====
// Ten-bit code window decompressor.
// Compressed bytes arrive on comp_i, one per transaction, and are shifted in
// most significant bit first to form 10-bit codes. A literal code produces one
// byte on dec_o and is stored in a 256-byte history window; a copy code
// produces 4, 8 or 16 bytes read out of the window from an absolute index,
// wrapping at the end. last_of_run marks the final byte caused by one input.
// An input byte that completes no code produces nothing and leaves comp_i
// ready. Otherwise the controller enters a literal or copy state, which loads
// the first result into the output register when the output slot is free;
// further copy bytes follow at one per cycle while dec_o takes them, set by
// the single window read port, and comp_i is ready again once the last
// result is loaded. The output register lets the next input be accepted
// while that result waits; when dec_o stalls, the block holds it and pauses.
// Reset is asynchronous and active low; it clears the code accumulator, the
// write pointer and a per-entry valid bit, so unwritten window slots read as
// zero at once with no clearing pass.
module ten_bit_code_window_decompressor
  import tbcwd_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  tbcwd_in_if.sink     comp_i,
  tbcwd_out_if.source  dec_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  tbcwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (comp_i.valid),
    .in_ready_o (comp_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbcwd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .code_byte_i   (comp_i.code_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (dec_o.valid),
    .out_ready_i   (dec_o.ready),
    .plain_byte_o  (dec_o.plain_byte),
    .last_of_run_o (dec_o.last_of_run)
  );

endmodule
